@@ design/stp_pkg.sv @@
// ----------------------------------------------------------------------------
// stp_pkg
// Shared types and constants for the speaker toggle to PCM block.
// ----------------------------------------------------------------------------
package stp_pkg;

  localparam int CYC_W      = 40;  // CPU cycle count
  localparam int TICK_W     = 41;  // signed last sent tick
  localparam int CALC_W     = 42;  // signed working width for tick math
  localparam int COUNT_W    = 7;   // sample count field
  localparam int SAMPLE_W   = 8;
  localparam int SPAN_W     = 21;  // largest span or threshold over the parameter range
  localparam int AUDIO_RATE = 44100;
  localparam logic [SAMPLE_W-1:0] FULL_LEVEL = 8'hff;

  typedef enum logic {
    OP_TOGGLE  = 1'b0,
    OP_REQUEST = 1'b1
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [CYC_W-1:0]   cyc;    // toggle cycle or current cycle
    logic [COUNT_W-1:0] count;  // clamped sample count
    logic [SPAN_W-1:0]  span;   // ticks covered by the buffer
  } cmd_t;

endpackage

@@ design/stp_front.sv @@
// ----------------------------------------------------------------------------
// stp_front
// Input stage: takes items, clamps the count and looks up the tick span.
// ----------------------------------------------------------------------------
module stp_front #(
  parameter int FRAME_CYCLES      = 17030,
  parameter int FRAMES_PER_SECOND = 60,
  parameter int MAX_SAMPLES       = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  stp_pkg::op_t                 in_op,
  input  logic [stp_pkg::CYC_W-1:0]    toggle_cycle,
  input  logic [stp_pkg::COUNT_W-1:0]  sample_count,
  input  logic [stp_pkg::CYC_W-1:0]    now_cycle,
  output logic                         cmd_valid,
  input  logic                         cmd_ready,
  output stp_pkg::cmd_t                cmd
);
  import stp_pkg::*;

  localparam int    CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam longint TPS  = longint'(FRAME_CYCLES) * longint'(FRAMES_PER_SECOND);

  logic [SPAN_W-1:0]  span_tab [MAX_SAMPLES+1];
  logic [COUNT_W-1:0] count_clamped;
  logic               vld;
  cmd_t               cmd_reg;

  for (genvar g = 0; g <= MAX_SAMPLES; g++) begin : g_span
    assign span_tab[g] = SPAN_W'((longint'(g) * TPS) / AUDIO_RATE);
  end

  assign count_clamped = (sample_count > COUNT_W'(MAX_SAMPLES)) ?
                         COUNT_W'(MAX_SAMPLES) : sample_count;

  assign in_ready  = !vld || cmd_ready;
  assign cmd_valid = vld;
  assign cmd       = cmd_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_valid && in_ready) begin
      vld <= 1'b1;
    end else if (cmd_ready) begin
      vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_reg.op    <= in_op;
      cmd_reg.cyc   <= (in_op == OP_REQUEST) ? now_cycle : toggle_cycle;
      cmd_reg.count <= count_clamped;
      cmd_reg.span  <= span_tab[count_clamped[CNT_W-1:0]];
    end
  end

endmodule

@@ design/stp_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// stp_cmd_fifo
// Two-entry command queue between the input stage and the engine.
// ----------------------------------------------------------------------------
module stp_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  stp_pkg::cmd_t in_cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output stp_pkg::cmd_t out_cmd
);
  import stp_pkg::*;

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       push;
  logic       pop;

  assign in_ready  = (cnt != 2'd2);
  assign out_valid = (cnt != 2'd0);
  assign out_cmd   = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_cmd;
    end
  end

endmodule

@@ design/stp_back.sv @@
// ----------------------------------------------------------------------------
// stp_back
// Engine: holds the toggle ring, replays toggles into samples, drives output.
// ----------------------------------------------------------------------------
module stp_back #(
  parameter int QUEUE_DEPTH       = 256,
  parameter int FRAME_CYCLES      = 17030,
  parameter int FRAMES_PER_SECOND = 60,
  parameter int MAX_SAMPLES       = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  stp_pkg::cmd_t                 cmd,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [stp_pkg::SAMPLE_W-1:0]  out_sample,
  output logic                          out_last
);
  import stp_pkg::*;

  localparam int     QA_W   = $clog2(QUEUE_DEPTH);
  localparam int     FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int     CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam longint TPS    = longint'(FRAME_CYCLES) * longint'(FRAMES_PER_SECOND);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PLAN  = 6'b000010,
    S_FETCH = 6'b000100,
    S_CHECK = 6'b001000,
    S_FILL  = 6'b010000,
    S_REST  = 6'b100000
  } state_t;

  state_t state;

  logic [CYC_W-1:0]     mem [QUEUE_DEPTH];
  logic [CYC_W-1:0]     rd_data;
  logic [QA_W-1:0]      head;
  logic [QA_W-1:0]      tail;
  logic [FILL_W-1:0]    fill;
  logic [SAMPLE_W-1:0]  level;
  logic signed [TICK_W-1:0] last_sent;
  logic [CYC_W-1:0]     now;
  logic [COUNT_W-1:0]   count;
  logic [SPAN_W-1:0]    span;
  logic [COUNT_W-1:0]   pos;
  logic signed [CALC_W-1:0] stop;
  logic signed [CALC_W-1:0] pulse;
  logic                 out_vld;

  logic [SPAN_W-1:0]    thr_tab [MAX_SAMPLES+1];
  logic [COUNT_W-1:0]   pos_inc;
  logic [SPAN_W-1:0]    thr_sel;
  logic signed [CALC_W-1:0] start_x;
  logic signed [CALC_W-1:0] now_x;
  logic signed [CALC_W-1:0] sum;
  logic signed [CALC_W-1:0] behind;
  logic signed [CALC_W-1:0] t_x;
  logic                 out_free;
  logic                 emit;
  logic                 fill_more;
  logic                 rest_more;

  for (genvar g = 0; g <= MAX_SAMPLES; g++) begin : g_thr
    assign thr_tab[g] = SPAN_W'((longint'(g) * TPS + AUDIO_RATE - 1) / AUDIO_RATE);
  end

  assign pos_inc   = pos + COUNT_W'(1);
  assign thr_sel   = thr_tab[pos_inc[CNT_W-1:0]];
  assign start_x   = CALC_W'(last_sent);
  assign now_x     = $signed({{(CALC_W-CYC_W){1'b0}}, now});
  assign sum       = start_x + $signed({{(CALC_W-SPAN_W){1'b0}}, span});
  assign behind    = now_x - stop;
  assign t_x       = $signed({{(CALC_W-CYC_W){1'b0}}, rd_data});
  assign out_free  = !out_vld || out_ready;
  assign fill_more = (pos < count) && (pulse >= $signed({{(CALC_W-SPAN_W){1'b0}}, thr_sel}));
  assign rest_more = (pos < count);
  assign emit      = out_free && (((state == S_FILL) && fill_more) ||
                                  ((state == S_REST) && rest_more));

  assign cmd_ready = (state == S_IDLE);
  assign out_valid = out_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      fill      <= '0;
      level     <= '0;
      last_sent <= '0;
      out_vld   <= 1'b0;
    end else begin
      if (emit) begin
        out_vld <= 1'b1;
      end else if (out_ready) begin
        out_vld <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            if (cmd.op == OP_REQUEST) begin
              state <= S_PLAN;
            end else if (fill < FILL_W'(QUEUE_DEPTH)) begin
              head <= (head == QA_W'(QUEUE_DEPTH - 1)) ? '0 : head + QA_W'(1);
              fill <= fill + FILL_W'(1);
            end
          end
        end
        S_PLAN: begin
          state <= S_FETCH;
        end
        S_FETCH: begin
          state <= (fill == '0) ? S_REST : S_CHECK;
        end
        S_CHECK: begin
          if (t_x < stop) begin
            tail  <= (tail == QA_W'(QUEUE_DEPTH - 1)) ? '0 : tail + QA_W'(1);
            fill  <= fill - FILL_W'(1);
            state <= S_FILL;
          end else begin
            state <= S_REST;
          end
        end
        S_FILL: begin
          if (!fill_more) begin
            level <= FULL_LEVEL - level;
            state <= S_FETCH;
          end
        end
        S_REST: begin
          if (!rest_more) begin
            if (behind > $signed(CALC_W'(3 * FRAME_CYCLES))) begin
              last_sent <= TICK_W'(now_x - $signed(CALC_W'(2 * FRAME_CYCLES)));
            end else begin
              last_sent <= TICK_W'(stop);
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && cmd_valid && (cmd.op == OP_TOGGLE) &&
        (fill < FILL_W'(QUEUE_DEPTH))) begin
      mem[head] <= cmd.cyc;
    end
    if (state == S_FETCH) begin
      rd_data <= mem[tail];
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && cmd_valid && (cmd.op == OP_REQUEST)) begin
      now   <= cmd.cyc;
      count <= cmd.count;
      span  <= cmd.span;
    end
    if (state == S_PLAN) begin
      stop <= (sum > now_x) ? (now_x - $signed(CALC_W'(FRAME_CYCLES))) : sum;
    end
    if ((state == S_CHECK) && (t_x < stop)) begin
      pulse <= t_x - start_x;
    end
    if (state == S_IDLE) begin
      pos <= '0;
    end else if (emit) begin
      pos <= pos_inc;
    end
    if (emit) begin
      out_sample <= level;
      out_last   <= (pos_inc == count);
    end
  end

endmodule

@@ design/speaker_toggle_to_pcm.sv @@
// ----------------------------------------------------------------------------
// speaker_toggle_to_pcm
// Converts queued speaker toggle times into 8-bit square-wave PCM at 44100 Hz.
// ----------------------------------------------------------------------------
// Toggle items (tuser 0) go into a ring of QUEUE_DEPTH entries and are dropped
// when it is full. A request item (tuser 1) gives out its clamped sample count
// as a burst of samples, tlast on the final one. The engine works one item at a
// time: a request steps through the plan, fetch and check states, replays each
// queued toggle before its stop point into samples, then pads the rest of the
// burst at the last level; the samples are paced by the output handshake. A
// two-entry command queue and an input register let new items be taken while
// the engine is busy.
// ----------------------------------------------------------------------------
module speaker_toggle_to_pcm #(
  parameter int QUEUE_DEPTH       = 256,
  parameter int FRAME_CYCLES      = 17030,
  parameter int FRAMES_PER_SECOND = 60,
  parameter int MAX_SAMPLES       = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [87:0] s_tdata,   // toggle_cycle[39:0], sample_count[46:40], now_cycle[86:47]
  input  logic        s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // sample[7:0]
  output logic        m_tlast
);
  import stp_pkg::*;

  cmd_t front_cmd;
  cmd_t back_cmd;
  logic front_valid;
  logic front_ready;
  logic back_valid;
  logic back_ready;
  op_t  in_op;

  assign in_op = op_t'(s_tuser);

  stp_front #(
    .FRAME_CYCLES     (FRAME_CYCLES),
    .FRAMES_PER_SECOND(FRAMES_PER_SECOND),
    .MAX_SAMPLES      (MAX_SAMPLES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_op       (in_op),
    .toggle_cycle(s_tdata[39:0]),
    .sample_count(s_tdata[46:40]),
    .now_cycle   (s_tdata[86:47]),
    .cmd_valid   (front_valid),
    .cmd_ready   (front_ready),
    .cmd         (front_cmd)
  );

  stp_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .in_valid (front_valid),
    .in_ready (front_ready),
    .in_cmd   (front_cmd),
    .out_valid(back_valid),
    .out_ready(back_ready),
    .out_cmd  (back_cmd)
  );

  stp_back #(
    .QUEUE_DEPTH      (QUEUE_DEPTH),
    .FRAME_CYCLES     (FRAME_CYCLES),
    .FRAMES_PER_SECOND(FRAMES_PER_SECOND),
    .MAX_SAMPLES      (MAX_SAMPLES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (back_valid),
    .cmd_ready (back_ready),
    .cmd       (back_cmd),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_sample(m_tdata),
    .out_last  (m_tlast)
  );

endmodule
